@@ design/lde_pkg.sv @@
// Shared types and constants of the LEDBAT delay estimator.
package lde_pkg;

    localparam int DATA_W      = 16;
    localparam int NOW_W       = 32;
    localparam int NOISE_LEN_W = 4;
    localparam int HIST_LEN_W  = 5;
    localparam int ROLL_W      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [DATA_W-1:0] RTT_CAP    = 16'hFFFE;
    localparam logic [DATA_W-1:0] EMPTY_MARK = 16'hFFFF;

    localparam logic [NOISE_LEN_W-1:0] NOISE_LEN_RST = 4'd4;
    localparam logic [HIST_LEN_W-1:0]  HIST_LEN_RST  = 5'd10;
    localparam logic [ROLL_W-1:0]      ROLL_SEC_RST  = 16'd60;

    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIST_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROLL_SEC  = 2'd2;

    // What a request does to one min-tracking store.
    typedef enum logic [1:0] {
        HOP_NONE,
        HOP_PUSH,
        HOP_LOWER
    } t_hop;

    typedef struct packed {
        logic [DATA_W-1:0] rtt;
        logic              rtt_valid;
        t_hop              hop;
        logic              delay_valid;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0] cur_dly;
        logic [DATA_W-1:0] base_dly;
        logic [DATA_W-1:0] queue_dly;
        logic              delay_valid;
    } t_result;

    typedef struct packed {
        logic              start;
        t_hop              op;
        logic [DATA_W-1:0] value;
    } t_mq_cmd;

    typedef struct packed {
        logic              busy;
        logic [DATA_W-1:0] min_value;
    } t_mq_stat;

endpackage

@@ design/lde_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lde_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

@@ design/lde_fifo.sv @@
// Small register queue used between the front and back and on the result side.
module lde_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ design/lde_front.sv @@
// Front end: saturates the sample and decides how the base history is updated.
module lde_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic [lde_pkg::DATA_W-1:0]       i_rtt_ms,
    input  logic                             i_rtt_valid,
    input  logic [lde_pkg::NOW_W-1:0]        i_now_seconds,
    input  logic                             i_timestamps_present,
    input  logic [lde_pkg::ROLL_W-1:0]       i_roll_sec,
    output lde_pkg::t_item                   o_item
);

    logic                        r_hist_seen;
    logic [lde_pkg::NOW_W-1:0]   r_last_roll;
    logic [lde_pkg::NOW_W-1:0]   elapsed;
    logic                        roll_due;
    logic [lde_pkg::DATA_W-1:0]  rtt_sat;

    assign rtt_sat  = (i_rtt_ms > lde_pkg::RTT_CAP) ? lde_pkg::RTT_CAP : i_rtt_ms;
    // Elapsed time wraps modulo 2^32, so time going backwards normally rolls over.
    assign elapsed  = i_now_seconds - r_last_roll;
    assign roll_due = (elapsed > lde_pkg::NOW_W'(i_roll_sec));

    always_comb begin
        o_item.rtt         = rtt_sat;
        o_item.rtt_valid   = i_rtt_valid;
        o_item.delay_valid = i_timestamps_present;
        if (!i_rtt_valid) begin
            o_item.hop = lde_pkg::HOP_NONE;
        end else if (!r_hist_seen || roll_due) begin
            o_item.hop = lde_pkg::HOP_PUSH;
        end else begin
            o_item.hop = lde_pkg::HOP_LOWER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_seen <= 1'b0;
            r_last_roll <= '0;
        end else if (i_accept && i_rtt_valid) begin
            // The very first history entry leaves the rollover time alone.
            if (!r_hist_seen) begin
                r_hist_seen <= 1'b1;
            end else if (roll_due) begin
                r_last_roll <= i_now_seconds;
            end
        end
    end

endmodule

@@ design/lde_minq.sv @@
// Min-tracking circular store: append with eviction, lowering of the newest
// entry, and a rescan of the kept entries after each eviction.
module lde_minq #(
    parameter int DEPTH = 8,
    parameter int CFG_W = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CFG_W-1:0]  i_len_cfg,
    input  lde_pkg::t_mq_cmd  i_cmd,
    output lde_pkg::t_mq_stat o_stat
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state                      r_state, n_state;
    logic [AW-1:0]               r_head, n_head;
    logic [CW-1:0]               r_count, n_count;
    logic [lde_pkg::DATA_W-1:0]  r_min, n_min;
    logic [lde_pkg::DATA_W-1:0]  r_last, n_last;
    logic [AW-1:0]               r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]               r_left, n_left;
    logic                        r_rd_vld, n_rd_vld;

    logic [31:0]                 len_ext;
    logic [CW-1:0]               len_eff;
    logic [CW:0]                 tail_sum;
    logic [CW:0]                 last_sum;
    logic [AW-1:0]               tail_addr;
    logic [AW-1:0]               last_addr;
    logic [AW-1:0]               head_inc;
    logic [AW-1:0]               rd_inc;
    logic [CW-1:0]               count_inc;

    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic                        rd_en;
    logic [lde_pkg::DATA_W-1:0]  rd_data;

    assign len_ext = 32'(i_len_cfg);

    always_comb begin
        if (len_ext < 32'd2) begin
            len_eff = CW'(2);
        end else if (len_ext > 32'(DEPTH)) begin
            len_eff = CW'(DEPTH);
        end else begin
            len_eff = CW'(len_ext);
        end
    end

    assign tail_sum  = (CW+1)'(r_head) + (CW+1)'(r_count);
    assign last_sum  = (CW+1)'(r_head) + (CW+1)'(r_count - CW'(1));
    assign tail_addr = (tail_sum >= (CW+1)'(DEPTH)) ? AW'(tail_sum - (CW+1)'(DEPTH))
                                                     : AW'(tail_sum);
    assign last_addr = (last_sum >= (CW+1)'(DEPTH)) ? AW'(last_sum - (CW+1)'(DEPTH))
                                                     : AW'(last_sum);
    assign head_inc  = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign rd_inc    = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
    assign count_inc = r_count + CW'(1);

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_count  = r_count;
        n_min    = r_min;
        n_last   = r_last;
        n_rd_ptr = r_rd_ptr;
        n_left   = r_left;
        n_rd_vld = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = tail_addr;
        rd_en    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.start) begin
                    unique case (i_cmd.op)
                        lde_pkg::HOP_PUSH: begin
                            wr_en  = 1'b1;
                            n_last = i_cmd.value;
                            if (r_count == '0) begin
                                n_count = CW'(1);
                                n_min   = i_cmd.value;
                            end else if (count_inc >= len_eff) begin
                                // Oldest entry drops out; the count stays and the
                                // older kept entries are rescanned against the new one.
                                n_head   = head_inc;
                                n_min    = i_cmd.value;
                                n_rd_ptr = head_inc;
                                n_left   = r_count - CW'(1);
                                n_state  = S_SCAN;
                            end else begin
                                n_count = count_inc;
                                if (i_cmd.value < r_min) begin
                                    n_min = i_cmd.value;
                                end
                            end
                        end
                        lde_pkg::HOP_LOWER: begin
                            if (i_cmd.value < r_last) begin
                                wr_en   = 1'b1;
                                wr_addr = last_addr;
                                n_last  = i_cmd.value;
                                if (i_cmd.value < r_min) begin
                                    n_min = i_cmd.value;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_left != '0) begin
                    rd_en    = 1'b1;
                    n_rd_ptr = rd_inc;
                    n_left   = r_left - CW'(1);
                    n_rd_vld = 1'b1;
                end
                if (r_rd_vld && (rd_data < r_min)) begin
                    n_min = rd_data;
                end
                if ((r_left == '0) && !r_rd_vld) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_rd_ptr <= '0;
            r_left   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_rd_ptr <= n_rd_ptr;
            r_left   <= n_left;
            r_rd_vld <= n_rd_vld;
        end
        r_min  <= n_min;
        r_last <= n_last;
    end

    lde_ram #(
        .WIDTH (lde_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_cmd.value),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (rd_data)
    );

    assign o_stat.busy      = (r_state != S_IDLE);
    assign o_stat.min_value = (r_count == '0) ? lde_pkg::EMPTY_MARK : r_min;

endmodule

@@ design/lde_back.sv @@
// Back end: applies one request to the noise window and base history, then
// forms the result.
module lde_back #(
    parameter int MAX_NOISE_LEN   = 8,
    parameter int MAX_HISTORY_LEN = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [lde_pkg::NOISE_LEN_W-1:0]   i_noise_len,
    input  logic [lde_pkg::HIST_LEN_W-1:0]    i_hist_len,
    input  lde_pkg::t_item                    i_item,
    input  logic                              i_item_empty,
    output logic                              o_item_pop,
    input  logic                              i_res_full,
    output logic                              o_res_push,
    output lde_pkg::t_result                  o_res
);

    typedef enum logic {
        B_IDLE,
        B_WAIT
    } t_state;

    t_state                      r_state;
    logic                        r_delay_valid;
    lde_pkg::t_mq_cmd            noise_cmd;
    lde_pkg::t_mq_cmd            hist_cmd;
    lde_pkg::t_mq_stat           noise_stat;
    lde_pkg::t_mq_stat           hist_stat;
    logic [lde_pkg::DATA_W-1:0]  cur;
    logic [lde_pkg::DATA_W-1:0]  base;

    assign o_item_pop = (r_state == B_IDLE) && !i_item_empty;

    always_comb begin
        noise_cmd.start = o_item_pop;
        noise_cmd.op    = i_item.rtt_valid ? lde_pkg::HOP_PUSH : lde_pkg::HOP_NONE;
        noise_cmd.value = i_item.rtt;
        hist_cmd.start  = o_item_pop;
        hist_cmd.op     = i_item.hop;
        hist_cmd.value  = i_item.rtt;
    end

    lde_minq #(
        .DEPTH (MAX_NOISE_LEN),
        .CFG_W (lde_pkg::NOISE_LEN_W)
    ) u_noise (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_len_cfg (i_noise_len),
        .i_cmd     (noise_cmd),
        .o_stat    (noise_stat)
    );

    lde_minq #(
        .DEPTH (MAX_HISTORY_LEN),
        .CFG_W (lde_pkg::HIST_LEN_W)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_len_cfg (i_hist_len),
        .i_cmd     (hist_cmd),
        .o_stat    (hist_stat)
    );

    assign cur  = noise_stat.min_value;
    assign base = hist_stat.min_value;

    assign o_res_push = (r_state == B_WAIT) && !noise_stat.busy && !hist_stat.busy
                        && !i_res_full;

    always_comb begin
        o_res.cur_dly     = cur;
        o_res.base_dly    = base;
        o_res.queue_dly   = (cur > base) ? (cur - base) : (base - cur);
        o_res.delay_valid = r_delay_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (o_item_pop) begin
                        r_state <= B_WAIT;
                    end
                end
                B_WAIT: begin
                    if (o_res_push) begin
                        r_state <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
        if (o_item_pop) begin
            r_delay_valid <= i_item.delay_valid;
        end
    end

endmodule

@@ design/ledbat_delay_estimator_unit.sv @@
// Top level of the LEDBAT current-delay and base-delay minimum filter.
// Each accepted request gives exactly one result, in order. Requests are queued, and
// the back end applies each one to both stores and pushes its result into the result
// queue once neither store is busy and that queue has room; it takes a new request
// only after pushing the result of the last one. When the noise window or base
// history evicts its oldest entry, its other kept entries are rescanned one memory
// read per cycle before the result is pushed. Two requests and two results can be
// buffered, so requests are taken while a finished result waits to be popped.
// Configuration writes are always accepted; the rollover time applies to requests
// accepted after the write, and the store lengths apply to every request that the
// back end takes after it, also to requests that were already queued.
module ledbat_delay_estimator_unit #(
    parameter int MAX_NOISE_LEN   = 8,
    parameter int MAX_HISTORY_LEN = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [lde_pkg::DATA_W-1:0]        i_rtt_ms,
    input  logic                              i_rtt_valid,
    input  logic [lde_pkg::NOW_W-1:0]         i_now_seconds,
    input  logic                              i_timestamps_present,
    output logic                              empty,
    input  logic                              pop,
    output logic [lde_pkg::DATA_W-1:0]        o_cur_dly,
    output logic [lde_pkg::DATA_W-1:0]        o_base_dly,
    output logic [lde_pkg::DATA_W-1:0]        o_queue_dly,
    output logic                              o_delay_valid,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lde_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lde_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int ITEM_W = $bits(lde_pkg::t_item);
    localparam int RES_W  = $bits(lde_pkg::t_result);

    logic [lde_pkg::NOISE_LEN_W-1:0] r_noise_len;
    logic [lde_pkg::HIST_LEN_W-1:0]  r_hist_len;
    logic [lde_pkg::ROLL_W-1:0]      r_roll_sec;

    logic                  in_accept;
    lde_pkg::t_item        front_item;
    logic [ITEM_W-1:0]     mid_data;
    lde_pkg::t_item        back_item;
    logic                  mid_empty;
    logic                  mid_pop;
    logic                  res_full;
    logic                  res_push;
    lde_pkg::t_result      back_res;
    logic [RES_W-1:0]      res_data;
    lde_pkg::t_result      out_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise_len <= lde_pkg::NOISE_LEN_RST;
            r_hist_len  <= lde_pkg::HIST_LEN_RST;
            r_roll_sec  <= lde_pkg::ROLL_SEC_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                lde_pkg::CFG_NOISE_LEN: r_noise_len <= i_cfg_data[lde_pkg::NOISE_LEN_W-1:0];
                lde_pkg::CFG_HIST_LEN:  r_hist_len  <= i_cfg_data[lde_pkg::HIST_LEN_W-1:0];
                lde_pkg::CFG_ROLL_SEC:  r_roll_sec  <= i_cfg_data[lde_pkg::ROLL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign in_accept = push && !full;

    lde_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_accept             (in_accept),
        .i_rtt_ms             (i_rtt_ms),
        .i_rtt_valid          (i_rtt_valid),
        .i_now_seconds        (i_now_seconds),
        .i_timestamps_present (i_timestamps_present),
        .i_roll_sec           (r_roll_sec),
        .o_item               (front_item)
    );

    lde_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (lde_pkg::QUEUE_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_data  (front_item),
        .o_full  (full),
        .i_pop   (mid_pop),
        .o_data  (mid_data),
        .o_empty (mid_empty)
    );

    assign back_item = lde_pkg::t_item'(mid_data);

    lde_back #(
        .MAX_NOISE_LEN   (MAX_NOISE_LEN),
        .MAX_HISTORY_LEN (MAX_HISTORY_LEN)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_noise_len  (r_noise_len),
        .i_hist_len   (r_hist_len),
        .i_item       (back_item),
        .i_item_empty (mid_empty),
        .o_item_pop   (mid_pop),
        .i_res_full   (res_full),
        .o_res_push   (res_push),
        .o_res        (back_res)
    );

    lde_fifo #(
        .WIDTH (RES_W),
        .DEPTH (lde_pkg::QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_data),
        .o_empty (empty)
    );

    assign out_res       = lde_pkg::t_result'(res_data);
    assign o_cur_dly     = out_res.cur_dly;
    assign o_base_dly    = out_res.base_dly;
    assign o_queue_dly   = out_res.queue_dly;
    assign o_delay_valid = out_res.delay_valid;

endmodule

@@ design/lde_chk.sv @@
// Port-level checks of the delay estimator, bound to its top level.
module lde_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           full,
    input logic                           empty,
    input logic [lde_pkg::DATA_W-1:0]     o_cur_dly,
    input logic [lde_pkg::DATA_W-1:0]     o_base_dly,
    input logic [lde_pkg::DATA_W-1:0]     o_queue_dly
);

    // Both queues come out of reset with nothing in them.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

    // The queue delay shown is always the distance between the two minima.
    a_queue_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_queue_dly == ((o_cur_dly > o_base_dly)
                                    ? (o_cur_dly - o_base_dly)
                                    : (o_base_dly - o_cur_dly))))
        else $error("queue delay does not match current and base delay");

    // Every recorded sample also reaches the history, so a non-empty window
    // implies a non-empty history.
    a_base_follows_current: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_cur_dly != lde_pkg::EMPTY_MARK))
            |-> (o_base_dly != lde_pkg::EMPTY_MARK))
        else $error("current delay present while base history is empty");

    // No stored sample can exceed the saturation cap.
    a_current_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_cur_dly <= lde_pkg::RTT_CAP)
                    || (o_cur_dly == lde_pkg::EMPTY_MARK)))
        else $error("current delay above the saturation cap");

endmodule

bind ledbat_delay_estimator_unit lde_chk u_lde_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .full        (full),
    .empty       (empty),
    .o_cur_dly   (o_cur_dly),
    .o_base_dly  (o_base_dly),
    .o_queue_dly (o_queue_dly)
);

@@ bench/delay_check_pkg.sv @@
`timescale 1ns / 1ps
// Checking classes for the LEDBAT delay estimator: min-tracking stores and the result checker.
package delay_check_pkg;

    localparam int NOISE_DEPTH = 8;
    localparam int HIST_DEPTH  = 16;

    // A store that keeps its newest entries and tracks where the smallest one sits.
    class min_fifo;
        logic [lde_pkg::DATA_W-1:0] st[];
        int unsigned cnt;
        int unsigned mi;
        int unsigned cap;
        int unsigned evictions;

        function new(int unsigned depth);
            cap = depth;
            st = new[depth];
            cnt = 0;
            mi = 0;
            evictions = 0;
        endfunction

        function void push(int unsigned len, logic [lde_pkg::DATA_W-1:0] v);
            int unsigned n;
            n = (cnt >= cap) ? cap - 1 : cnt;
            if (mi >= cap) mi = 0;
            if (n == 0) begin
                st[0] = v;
                cnt = 1;
                mi = 0;
                return;
            end
            st[n] = v;
            n++;
            if (st[mi] > v) mi = n - 1;
            // Reaching the length drops only the oldest entry, so a shrunk
            // length leaves the count where it was.
            if (n >= len) begin
                for (int i = 0; i < n - 1; i++) st[i] = st[i + 1];
                n--;
                evictions++;
                mi = 0;
                for (int i = 1; i < n; i++) if (st[i] < st[mi]) mi = i;
            end
            cnt = n;
        endfunction

        function void lower_newest(logic [lde_pkg::DATA_W-1:0] v);
            int unsigned last;
            last = (cnt - 1 >= cap) ? cap - 1 : cnt - 1;
            if (mi >= cap) mi = 0;
            if (v < st[last]) begin
                st[last] = v;
                if (v < st[mi]) mi = last;
            end
        endfunction

        function logic [lde_pkg::DATA_W-1:0] lowest();
            if (cnt == 0 || mi >= cap) return lde_pkg::EMPTY_MARK;
            return st[mi];
        endfunction
    endclass

    class min_delay_checker;
        min_fifo noise;
        min_fifo hist;
        logic [lde_pkg::NOW_W-1:0]       last_roll;
        logic [lde_pkg::NOISE_LEN_W-1:0] noise_len;
        logic [lde_pkg::HIST_LEN_W-1:0]  hist_len;
        logic [lde_pkg::ROLL_W-1:0]      roll_secs;
        lde_pkg::t_result expected_delays[$];
        int unsigned errors;
        int unsigned results_seen;
        int unsigned valid_samples;
        int unsigned new_entries;

        function new();
            noise = new(NOISE_DEPTH);
            hist = new(HIST_DEPTH);
            last_roll = '0;
            noise_len = lde_pkg::NOISE_LEN_RST;
            hist_len = lde_pkg::HIST_LEN_RST;
            roll_secs = lde_pkg::ROLL_SEC_RST;
            errors = 0;
            results_seen = 0;
            valid_samples = 0;
            new_entries = 0;
        endfunction

        function int unsigned clamp_len(int unsigned v, int unsigned hi);
            if (v < 2) return 2;
            if (v > hi) return hi;
            return v;
        endfunction

        function void set_reg(logic [lde_pkg::CFG_IDX_W-1:0] idx,
                              logic [lde_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                lde_pkg::CFG_NOISE_LEN: noise_len = data[lde_pkg::NOISE_LEN_W-1:0];
                lde_pkg::CFG_HIST_LEN:  hist_len = data[lde_pkg::HIST_LEN_W-1:0];
                lde_pkg::CFG_ROLL_SEC:  roll_secs = data[lde_pkg::ROLL_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return expected_delays.size();
        endfunction

        function void note_ack(logic [lde_pkg::DATA_W-1:0] rtt, logic ok,
                               logic [lde_pkg::NOW_W-1:0] now, logic ts);
            logic [lde_pkg::DATA_W-1:0] s;
            logic [lde_pkg::NOW_W-1:0]  elapsed;
            int unsigned                hl;
            lde_pkg::t_result           r;
            s = (rtt > lde_pkg::RTT_CAP) ? lde_pkg::RTT_CAP : rtt;
            hl = clamp_len(hist_len, HIST_DEPTH);
            if (ok) begin
                valid_samples++;
                noise.push(clamp_len(noise_len, NOISE_DEPTH), s);
                elapsed = now - last_roll;
                if (hist.cnt == 0) begin
                    // The very first entry leaves the rollover time alone.
                    hist.push(hl, s);
                    new_entries++;
                end else if (elapsed > {16'd0, roll_secs}) begin
                    last_roll = now;
                    hist.push(hl, s);
                    new_entries++;
                end else begin
                    hist.lower_newest(s);
                end
            end
            r.cur_dly = noise.lowest();
            r.base_dly = hist.lowest();
            r.queue_dly = (r.cur_dly > r.base_dly) ?
                          r.cur_dly - r.base_dly : r.base_dly - r.cur_dly;
            r.delay_valid = ts;
            expected_delays.insert(expected_delays.size(), r);
        endfunction

        task report(string what);
            errors++;
            $display("MISMATCH at %0t: %s", $time, what);
        endtask

        task check_delays(lde_pkg::t_result got);
            lde_pkg::t_result want;
            results_seen++;
            if (expected_delays.size() == 0) begin
                report($sformatf("result %0d arrived with no request pending", results_seen));
                return;
            end
            want = expected_delays.pop_front();
            if (got.cur_dly !== want.cur_dly)
                report($sformatf("result %0d current delay %0d, expected %0d",
                                 results_seen, got.cur_dly, want.cur_dly));
            if (got.base_dly !== want.base_dly)
                report($sformatf("result %0d base delay %0d, expected %0d",
                                 results_seen, got.base_dly, want.base_dly));
            if (got.queue_dly !== want.queue_dly)
                report($sformatf("result %0d queue delay %0d, expected %0d",
                                 results_seen, got.queue_dly, want.queue_dly));
            if (got.delay_valid !== want.delay_valid)
                report($sformatf("result %0d delay_valid %b, expected %b",
                                 results_seen, got.delay_valid, want.delay_valid));
        endtask
    endclass

endpackage

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Top-level testbench of the LEDBAT delay estimator: stimulus, handshakes and result checks.
module tb_top;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           push;
    logic                           full;
    logic [lde_pkg::DATA_W-1:0]     i_rtt_ms;
    logic                           i_rtt_valid;
    logic [lde_pkg::NOW_W-1:0]      i_now_seconds;
    logic                           i_timestamps_present;
    logic                           empty;
    logic                           pop;
    logic [lde_pkg::DATA_W-1:0]     o_cur_dly;
    logic [lde_pkg::DATA_W-1:0]     o_base_dly;
    logic [lde_pkg::DATA_W-1:0]     o_queue_dly;
    logic                           o_delay_valid;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [lde_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [lde_pkg::CFG_DATA_W-1:0] i_cfg_data;

    delay_check_pkg::min_delay_checker delays;
    bit                        steady;
    int unsigned               hold_left;
    int unsigned               acks_sent;
    int unsigned               settings_used;
    logic [lde_pkg::NOW_W-1:0] now_s;

    ledbat_delay_estimator_unit DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .push(push),
        .full(full),
        .i_rtt_ms(i_rtt_ms),
        .i_rtt_valid(i_rtt_valid),
        .i_now_seconds(i_now_seconds),
        .i_timestamps_present(i_timestamps_present),
        .empty(empty),
        .pop(pop),
        .o_cur_dly(o_cur_dly),
        .o_base_dly(o_base_dly),
        .o_queue_dly(o_queue_dly),
        .o_delay_valid(o_delay_valid),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_ack(input logic [lde_pkg::DATA_W-1:0] rtt, input logic ok,
                            input logic [lde_pkg::NOW_W-1:0] now, input logic ts);
        while (!steady && $urandom_range(99) < 36) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_rtt_ms <= rtt;
        i_rtt_valid <= ok;
        i_now_seconds <= now;
        i_timestamps_present <= ts;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        delays.note_ack(rtt, ok, now, ts);
        acks_sent++;
        @(negedge i_clk);
    endtask

    // Stop offering requests until every result is back, then let the pipeline go quiet.
    task automatic settle();
        push <= 1'b0;
        while (delays.pending() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic set_limits(input logic [lde_pkg::CFG_DATA_W-1:0] nl,
                              input logic [lde_pkg::CFG_DATA_W-1:0] hl,
                              input logic [lde_pkg::CFG_DATA_W-1:0] rs);
        logic [lde_pkg::CFG_IDX_W-1:0]  idx[3];
        logic [lde_pkg::CFG_DATA_W-1:0] val[3];
        idx = '{lde_pkg::CFG_NOISE_LEN, lde_pkg::CFG_HIST_LEN, lde_pkg::CFG_ROLL_SEC};
        val = '{nl, hl, rs};
        for (int k = 0; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data <= val[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            delays.set_reg(idx[k], val[k]);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic random_phase(input int unsigned n_acks);
        logic [lde_pkg::DATA_W-1:0] typical;
        logic [lde_pkg::DATA_W-1:0] rtt;
        logic [lde_pkg::NOW_W-1:0]  step;
        int unsigned                pick;
        typical = 16'($urandom_range(2000, 20));
        for (int k = 0; k < n_acks; k++) begin
            pick = $urandom_range(99);
            if (pick < 75) rtt = 16'(typical + $urandom_range(300));
            else if (pick < 90) rtt = 16'($urandom);
            else if (pick < 95) rtt = 16'($urandom_range(1));
            else rtt = 16'hFFFF - 16'($urandom_range(2));
            // Mostly small time steps, some right at the rollover boundary,
            // a few long jumps and the odd step backwards.
            pick = $urandom_range(99);
            if (pick < 70) step = $urandom_range(3);
            else if (pick < 88) step = delays.roll_secs + $urandom_range(2) - 1;
            else if (pick < 97) step = $urandom_range(200000);
            else step = -$urandom_range(100);
            now_s = now_s + step;
            send_ack(rtt, $urandom_range(99) < 90, now_s, $urandom_range(99) < 85);
        end
    endtask

    initial begin
        lde_pkg::t_result got;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_left != 0) begin
                pop <= 1'b0;
                hold_left--;
            end else begin
                pop <= steady || ($urandom_range(99) >= 36);
            end
            @(posedge i_clk);
            if (pop && !empty) begin
                got.cur_dly = o_cur_dly;
                got.base_dly = o_base_dly;
                got.queue_dly = o_queue_dly;
                got.delay_valid = o_delay_valid;
                delays.check_delays(got);
            end
        end
    end

    initial begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        logic [lde_pkg::CFG_DATA_W-1:0] nl;
        logic [lde_pkg::CFG_DATA_W-1:0] hl;
        logic [lde_pkg::CFG_DATA_W-1:0] rs;
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_rtt_ms = '0;
        i_rtt_valid = 1'b0;
        i_now_seconds = '0;
        i_timestamps_present = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = lde_pkg::CFG_NOISE_LEN;
        i_cfg_data = '0;
        steady = 0;
        hold_left = 0;
        acks_sent = 0;
        settings_used = 0;
        delays = new();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: empty stores, saturation, rollover boundary and time wrap.
        send_ack(16'd100, 1'b0, 32'd0, 1'b0);
        send_ack(16'd0, 1'b1, 32'd5, 1'b1);
        send_ack(16'hFFFF, 1'b1, 32'd10, 1'b1);
        send_ack(16'hFFFE, 1'b1, 32'd60, 1'b0);
        send_ack(16'd1, 1'b1, 32'd61, 1'b1);
        send_ack(16'hAAAA, 1'b1, 32'd100, 1'b1);
        send_ack(16'h5555, 1'b1, 32'd121, 1'b1);
        send_ack(16'd300, 1'b1, 32'd50, 1'b1);
        send_ack(16'd200, 1'b1, 32'hFFFF_FFF0, 1'b1);
        send_ack(16'd150, 1'b1, 32'd5, 1'b1);
        send_ack(16'hFFFF, 1'b0, 32'd6, 1'b1);
        settle();

        // Largest stores with no rollover hold-off, then shrink them while they still hold entries.
        set_limits(16'd8, 16'd16, 16'd0);
        for (int k = 0; k < 8; k++)
            send_ack(16'd900 - 16'(k * 70), 1'b1, 32'd1000 + 32'(k / 2), 1'b1);
        settle();
        set_limits(16'd2, 16'd2, 16'hFFFF);
        send_ack(16'd5000, 1'b1, 32'd2000, 1'b1);
        send_ack(16'd40, 1'b1, 32'd2001, 1'b0);
        settle();
        set_limits(16'd0, 16'd0, 16'd1);
        send_ack(16'd700, 1'b1, 32'd3000, 1'b1);
        send_ack(16'd650, 1'b1, 32'd3002, 1'b1);
        settle();
        set_limits(16'd15, 16'd31, 16'd60);
        send_ack(16'd800, 1'b1, 32'd4000, 1'b1);
        send_ack(16'd750, 1'b1, 32'd4100, 1'b1);
        now_s = 32'd4100;

        for (int p = 0; p < 8; p++) begin
            settle();
            nl = (p == 0) ? 16'd2 : (p == 1) ? 16'd8 : 16'($urandom_range(15));
            hl = (p == 0) ? 16'd16 : (p == 1) ? 16'd2 : 16'($urandom_range(31));
            case ($urandom_range(3))
                0: rs = 16'd0;
                1: rs = 16'($urandom_range(10));
                2: rs = 16'd60;
                default: rs = 16'($urandom);
            endcase
            set_limits(nl, hl, rs);
            if (p % 3 == 0) now_s = $urandom;
            if (p == 2) steady = 1;
            // The receiver stalls while requests keep coming, so the block backs up.
            if (p == 5) begin
                steady = 1;
                hold_left = 80;
            end
            random_phase(68);
            steady = 0;
        end

        settle();
        $display("Covered %0d acks (%0d valid samples, %0d new base entries) over %0d settings.",
                 acks_sent, delays.valid_samples, delays.new_entries, settings_used + 1);
        $display("Checked %0d results; %0d noise and %0d base evictions seen.",
                 delays.results_seen, delays.noise.evictions, delays.hist.evictions);
        if (delays.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
